// ===== rtl/sgmpa_pkg.sv =====
// Shared types and constants of the SGM path cost aggregation unit.
package sgmpa_pkg;

  // Default disparity range of the cost stores
  localparam int MAX_DISPARITIES_DEF = 64;

  // Field widths fixed by the interface
  localparam int COST_W     = 8;
  localparam int GRAY_W     = 8;
  localparam int IDX_OUT_W  = 6;
  localparam int DCOUNT_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Cost of a missing neighbour at either end of the disparity range
  localparam logic [COST_W-1:0] EDGE_COST = 8'd255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_SMALL      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_LARGE_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPARITY_COUNT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_P2_MODE            = 2'd3;

  // Reset values of the configuration registers
  localparam logic [COST_W-1:0]   PENALTY_SMALL_RST      = 8'd10;
  localparam logic [COST_W-1:0]   PENALTY_LARGE_BASE_RST = 8'd150;
  localparam logic [DCOUNT_W-1:0] DISPARITY_COUNT_RST    = 7'd64;

  // One matching cost item
  typedef struct packed {
    logic [COST_W-1:0] match_cost;
    logic [GRAY_W-1:0] pixel_gray;
    logic              path_start;
  } cost_item_t;

  // One aggregated path cost item
  typedef struct packed {
    logic [COST_W-1:0]    path_cost;
    logic [IDX_OUT_W-1:0] disparity_index;
    logic                 pixel_last;
  } path_item_t;

endpackage

// ===== rtl/sgm_path_cost_aggregation_unit.sv =====
// Top level of the SGM path cost aggregation unit.
//
// Aggregates semi-global matching costs along one path: one matching cost per
// transfer, disparities of a pixel in ascending order, pixel after pixel. Each
// input transfer gives exactly one path cost transfer. Within a pixel the unit
// takes one disparity per cycle while the output is not stalled; the first
// disparity of every pixel waits while a bit-serial divider works out the large
// penalty P2 from the gray step. The previous and current pixel costs live in
// one RAM of two banks, each MAX_DISPARITIES entries rounded up to a power of
// two; the banks swap on the last disparity of each pixel, and a three entry
// window over the previous pixel's costs is kept filled by prefetching one
// entry ahead. Results are held in a registered output stage.
module sgm_path_cost_aggregation_unit #(
  parameter int MAX_DISPARITIES = sgmpa_pkg::MAX_DISPARITIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_wr_en,
  input  logic [sgmpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgmpa_pkg::CFG_DATA_W-1:0] cfg_data,
  // matching cost channel
  input  logic                             cost_valid,
  output logic                             cost_stall,
  input  sgmpa_pkg::cost_item_t            cost_item,
  // path cost channel
  output logic                             path_valid,
  input  logic                             path_stall,
  output sgmpa_pkg::path_item_t            path_item
);

  import sgmpa_pkg::*;

  localparam int DISP_W = $clog2(MAX_DISPARITIES);
  localparam int ADDR_W = DISP_W + 1;
  localparam int CNT_W  = (DISP_W + 1 > DCOUNT_W) ? DISP_W + 1 : DCOUNT_W;
  localparam int DIV_STEPS = COST_W;
  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DISPARITIES);

  typedef enum logic {ST_RUN, ST_DIV} state_t;

  // configuration registers
  logic [COST_W-1:0]   penalty_small;
  logic [COST_W-1:0]   penalty_large_base;
  logic [DCOUNT_W-1:0] disparity_count;
  logic                p2_mode;

  // control and per-pixel state
  state_t              state;
  logic [STEP_W-1:0]   div_cnt;
  logic [DISP_W-1:0]   disp_cnt;
  logic                cur_bank;
  logic                in_first_pixel;
  logic [COST_W-1:0]   previous_minimum;
  logic [COST_W-1:0]   current_minimum;
  logic [GRAY_W-1:0]   previous_gray;
  logic [COST_W-1:0]   large_penalty_now;

  // divider
  logic [COST_W-1:0]   div_q;
  logic [COST_W-1:0]   div_rem;
  logic [COST_W:0]     div_den;
  logic [COST_W:0]     div_trial;
  logic                div_ge;
  logic [COST_W-1:0]   div_q_next;
  logic [COST_W-1:0]   div_rem_next;

  // processing stage
  logic                s1_valid;
  logic [COST_W-1:0]   s1_cost;
  logic [DISP_W-1:0]   s1_d;
  logic                s1_last;
  logic [COST_W-1:0]   win_lo;
  logic [COST_W-1:0]   win_mid;

  // RAM ports
  logic                ram_wr_en;
  logic [ADDR_W-1:0]   ram_wr_addr;
  logic                ram_rd_en;
  logic [ADDR_W-1:0]   ram_rd_addr;
  logic [COST_W-1:0]   ram_rd_data;

  // combinational helpers
  logic [CNT_W-1:0]    count_use;
  logic                last_now;
  logic                s1_move;
  logic                accept;
  logic [GRAY_W-1:0]   gray_step;
  logic [COST_W:0]     den_now;
  logic [COST_W:0]     edge_term;
  logic [COST_W:0]     lower_term;
  logic [COST_W:0]     upper_term;
  logic [COST_W:0]     same_term;
  logic [COST_W:0]     jump_term;
  logic [COST_W:0]     best_a;
  logic [COST_W:0]     best_b;
  logic [COST_W:0]     best;
  logic [COST_W-1:0]   result;
  logic [COST_W-1:0]   min_next;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      penalty_small      <= PENALTY_SMALL_RST;
      penalty_large_base <= PENALTY_LARGE_BASE_RST;
      disparity_count    <= DISPARITY_COUNT_RST;
      p2_mode            <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PENALTY_SMALL:      penalty_small      <= cfg_data;
        CFG_PENALTY_LARGE_BASE: penalty_large_base <= cfg_data;
        CFG_DISPARITY_COUNT:    disparity_count    <= cfg_data[DCOUNT_W-1:0];
        CFG_P2_MODE:            p2_mode            <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the disparity count and flag the pixel's last disparity
  always_comb begin
    if (disparity_count == '0) begin
      count_use = CNT_W'(1);
    end else if (CNT_W'(disparity_count) > MAX_CNT) begin
      count_use = MAX_CNT;
    end else begin
      count_use = CNT_W'(disparity_count);
    end
    last_now = (CNT_W'(disp_cnt) + CNT_W'(1)) >= count_use;
  end

  // Handshake: the stage moves when the output register is free or drained
  assign s1_move    = s1_valid && (!path_valid || !path_stall);
  assign cost_stall = !((state == ST_RUN) && (!s1_valid || s1_move));
  assign accept     = cost_valid && !cost_stall;

  // Gray step and divisor for P2
  always_comb begin
    gray_step = (cost_item.pixel_gray > previous_gray) ?
                cost_item.pixel_gray - previous_gray :
                previous_gray - cost_item.pixel_gray;
    if (!p2_mode) begin
      den_now = {1'b0, gray_step} + (COST_W+1)'(1);
    end else if (gray_step == '0) begin
      den_now = (COST_W+1)'(1);
    end else begin
      den_now = {1'b0, gray_step};
    end
  end

  // One restoring division step
  always_comb begin
    div_trial    = {div_rem, div_q[COST_W-1]};
    div_ge       = div_trial >= div_den;
    div_rem_next = div_ge ? COST_W'(div_trial - div_den) : div_trial[COST_W-1:0];
    div_q_next   = {div_q[COST_W-2:0], div_ge};
  end

  // Four candidate terms and their minimum
  always_comb begin
    edge_term  = {1'b0, EDGE_COST} + {1'b0, penalty_small};
    same_term  = {1'b0, win_mid};
    lower_term = (s1_d == '0) ? edge_term : {1'b0, win_lo} + {1'b0, penalty_small};
    upper_term = s1_last ? edge_term : {1'b0, ram_rd_data} + {1'b0, penalty_small};
    jump_term  = {1'b0, previous_minimum} + {1'b0, large_penalty_now};
    best_a     = (same_term < lower_term) ? same_term : lower_term;
    best_b     = (upper_term < jump_term) ? upper_term : jump_term;
    best       = (best_a < best_b) ? best_a : best_b;
    if (in_first_pixel) begin
      result = s1_cost;
    end else begin
      result = s1_cost + best[COST_W-1:0] - previous_minimum;
    end
    min_next = (result < current_minimum) ? result : current_minimum;
  end

  // Write the current cost; prefetch the previous pixel's costs one ahead
  always_comb begin
    ram_wr_en   = s1_move;
    ram_wr_addr = {cur_bank, s1_d};
    ram_rd_en   = 1'b0;
    ram_rd_addr = {!cur_bank, DISP_W'(disp_cnt + DISP_W'(1))};
    if (state == ST_DIV) begin
      if (div_cnt == STEP_W'(0)) begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = {!cur_bank, DISP_W'(0)};
      end else if (div_cnt == STEP_W'(1)) begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = {!cur_bank, DISP_W'(1)};
      end
    end else if (accept && disp_cnt != '0) begin
      ram_rd_en = 1'b1;
    end
  end

  sgmpa_ram #(
    .WIDTH (COST_W),
    .DEPTH (1 << ADDR_W)
  ) u_cost_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (result),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Sequencer, processing stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_RUN;
      div_cnt           <= '0;
      disp_cnt          <= '0;
      cur_bank          <= 1'b0;
      in_first_pixel    <= 1'b1;
      previous_minimum  <= EDGE_COST;
      current_minimum   <= EDGE_COST;
      previous_gray     <= '0;
      large_penalty_now <= '0;
      s1_valid          <= 1'b0;
      path_valid        <= 1'b0;
    end else begin
      // process the held cost and hand it to the output register;
      // drop the output once transferred
      if (s1_move) begin
        path_valid                <= 1'b1;
        path_item.path_cost       <= result;
        path_item.disparity_index <= IDX_OUT_W'(s1_d);
        path_item.pixel_last      <= s1_last;
        win_lo                    <= win_mid;
        win_mid                   <= ram_rd_data;
        if (s1_last) begin
          previous_minimum <= min_next;
          current_minimum  <= EDGE_COST;
          cur_bank         <= !cur_bank;
        end else begin
          current_minimum <= min_next;
        end
      end else if (!path_stall) begin
        path_valid <= 1'b0;
      end

      // accept a new cost, or empty the stage once it has moved
      if (accept) begin
        s1_cost  <= cost_item.match_cost;
        s1_d     <= disp_cnt;
        s1_last  <= last_now;
        disp_cnt <= last_now ? '0 : disp_cnt + DISP_W'(1);
        if (disp_cnt == '0) begin
          state          <= ST_DIV;
          div_cnt        <= '0;
          div_q          <= penalty_large_base;
          div_rem        <= '0;
          div_den        <= den_now;
          previous_gray  <= cost_item.pixel_gray;
          in_first_pixel <= cost_item.path_start;
          s1_valid       <= 1'b0;
        end else begin
          s1_valid <= 1'b1;
        end
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end

      // advance the divider and fill the window for disparity zero
      if (state == ST_DIV) begin
        div_q   <= div_q_next;
        div_rem <= div_rem_next;
        div_cnt <= div_cnt + STEP_W'(1);
        if (div_cnt == STEP_W'(1)) begin
          win_mid <= ram_rd_data;
        end
        if (div_cnt == STEP_W'(DIV_STEPS - 1)) begin
          large_penalty_now <= div_q_next;
          s1_valid          <= 1'b1;
          state             <= ST_RUN;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  // No costs are taken while the divider runs
  a_stall_in_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> cost_stall)
    else $error("cost accepted during P2 division");

  // The stage never holds a cost while the divider runs
  a_div_exclusive: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !s1_valid)
    else $error("stage valid during P2 division");

  // The first disparity of a pixel starts the divider
  a_first_starts_div: assert property (@(posedge clk) disable iff (rst)
    (accept && disp_cnt == '0) |=> (state == ST_DIV) && (div_cnt == '0))
    else $error("first disparity did not start the divider");

  // The counter wraps after the last disparity
  a_counter_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && last_now) |=> (disp_cnt == '0))
    else $error("disparity counter did not wrap");
`endif

endmodule

// ===== rtl/sgmpa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module sgmpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
